/* rtl/core/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_BACK   = 2'd3
  } deq_func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } deq_state_t;

  typedef struct packed {
    deq_func_t                  func;
    logic signed [WORD_W-1:0]   value;
  } deq_cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   popped;
    logic signed [WORD_W-1:0]   head_word;
    logic signed [WORD_W-1:0]   tail_word;
    logic                       nonempty;
    logic [COUNT_W-1:0]         count;
    logic                       underflow;
    logic                       overflow;
  } deq_res_t;

endpackage

`default_nettype wire

/* rtl/core/deq_if.sv */
// Valid/ready channels for queue commands and results.
`default_nettype none

interface deq_cmd_if;
  logic              valid;
  logic              ready;
  deq_pkg::deq_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface deq_res_if;
  logic              valid;
  logic              ready;
  deq_pkg::deq_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/double_ended_queue.sv */
// Bounded double-ended queue of 32-bit words kept in a ring memory.
// Result: pushes, rejected pushes, empty pops and pops that leave the queue empty
//   are loaded into the result register in the cycle after the item is taken; other pops go through ST_READ first.
// Throughput: 1 item per cycle for pushes while results are taken; after a pop that leaves words,
//   no new item is taken until the single memory read port has refilled the cached end word.
// Reset: puts head at slot 0 and tail at the last slot, clears the word count; the memory is not cleared.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  deq_cmd_if.sink        cmd,
  deq_res_if.source      res
);

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int WW = deq_pkg::WORD_W;
  localparam int CW = deq_pkg::COUNT_W;

  // Ring memory, one write and one registered read port.
  logic signed [WW-1:0] mem [DEPTH];
  logic signed [WW-1:0] rd_data;

  deq_pkg::deq_state_t  state, state_next;

  logic [IW-1:0]        head, head_next;
  logic [IW-1:0]        tail, tail_next;
  logic [OW-1:0]        occ, occ_next;
  logic signed [WW-1:0] head_word, head_word_next;
  logic signed [WW-1:0] tail_word, tail_word_next;
  logic signed [WW-1:0] pend_popped;
  logic                 pend_front;

  logic [IW-1:0]        head_inc, head_dec, tail_inc, tail_dec;
  logic                 full, empty, accept, cmd_ready, go_read, load_out;
  logic                 wr_en, rd_en;
  logic [IW-1:0]        wr_addr, rd_addr;
  logic signed [WW-1:0] popped_w;
  logic                 under_w, over_w;
  logic                 res_valid;
  deq_pkg::deq_res_t    res_data, res_next;

  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
  assign head_dec = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
  assign tail_inc = (tail == IW'(DEPTH - 1)) ? '0 : tail + IW'(1);
  assign tail_dec = (tail == '0) ? IW'(DEPTH - 1) : tail - IW'(1);

  assign full   = (occ == OW'(DEPTH));
  assign empty  = (occ == '0);
  assign accept = cmd.valid && cmd_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::ST_IDLE: if (go_read) state_next = deq_pkg::ST_READ;
      deq_pkg::ST_READ: state_next = deq_pkg::ST_IDLE;
      default:          state_next = deq_pkg::ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    case (state)
      deq_pkg::ST_IDLE: cmd_ready = !res_valid || res.ready;
      deq_pkg::ST_READ: cmd_ready = 1'b0;
      default:          cmd_ready = 1'b0;
    endcase
  end

  // Pointer, cached end words and result
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occ_next       = occ;
    head_word_next = head_word;
    tail_word_next = tail_word;
    wr_en          = 1'b0;
    wr_addr        = tail_inc;
    rd_en          = 1'b0;
    rd_addr        = head_inc;
    popped_w       = '0;
    under_w        = 1'b0;
    over_w         = 1'b0;
    go_read        = 1'b0;
    load_out       = 1'b0;

    if (state == deq_pkg::ST_READ) begin
      // Refill the cached end word exposed by the pop
      if (pend_front) head_word_next = rd_data;
      else            tail_word_next = rd_data;
      popped_w = pend_popped;
      load_out = 1'b1;
    end else if (accept) begin
      case (cmd.data.func)
        deq_pkg::FN_PUSH_FRONT: begin
          if (full) begin
            over_w = 1'b1;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = head_dec;
            head_next      = head_dec;
            head_word_next = cmd.data.value;
            if (empty) tail_word_next = cmd.data.value;
            occ_next       = occ + OW'(1);
          end
        end
        deq_pkg::FN_PUSH_BACK: begin
          if (full) begin
            over_w = 1'b1;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = tail_inc;
            tail_next      = tail_inc;
            tail_word_next = cmd.data.value;
            if (empty) head_word_next = cmd.data.value;
            occ_next       = occ + OW'(1);
          end
        end
        deq_pkg::FN_POP_FRONT: begin
          if (empty) begin
            under_w = 1'b1;
          end else begin
            popped_w  = head_word;
            head_next = head_inc;
            rd_addr   = head_inc;
            occ_next  = occ - OW'(1);
            go_read   = (occ_next != '0);
          end
        end
        deq_pkg::FN_POP_BACK: begin
          if (empty) begin
            under_w = 1'b1;
          end else begin
            popped_w  = tail_word;
            tail_next = tail_dec;
            rd_addr   = tail_dec;
            occ_next  = occ - OW'(1);
            go_read   = (occ_next != '0);
          end
        end
        default: begin
          under_w = 1'b0;
        end
      endcase
      rd_en    = go_read;
      load_out = !go_read;
    end

    res_next.popped    = popped_w;
    res_next.head_word = (occ_next != '0) ? head_word_next : '0;
    res_next.tail_word = (occ_next != '0) ? tail_word_next : '0;
    res_next.nonempty  = (occ_next != '0);
    res_next.count     = CW'(occ_next);
    res_next.underflow = under_w;
    res_next.overflow  = over_w;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.data.value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::ST_IDLE;
      head      <= '0;
      tail      <= IW'(DEPTH - 1);
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      if (load_out)       res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    head_word <= head_word_next;
    tail_word <= tail_word_next;
    if (go_read) begin
      pend_popped <= popped_w;
      pend_front  <= (cmd.data.func == deq_pkg::FN_POP_FRONT);
    end
    if (load_out) res_data <= res_next;
  end

  assign cmd.ready = cmd_ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(DEPTH))
    else $error("word count above depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == deq_pkg::ST_READ |-> !res_valid)
    else $error("result register busy while pop read is in flight");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    accept && !full && (cmd.data.func == deq_pkg::FN_PUSH_FRONT ||
                        cmd.data.func == deq_pkg::FN_PUSH_BACK)
    |=> occ == $past(occ) + OW'(1))
    else $error("push did not advance the word count");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == deq_pkg::ST_READ |=> res_valid)
    else $error("pop read did not produce a result");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for double_ended_queue: random mixed push/pop traffic against a ring mirror.
`default_nettype none

module tb;

  localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
  localparam int WW          = deq_pkg::WORD_W;
  localparam int CW          = deq_pkg::COUNT_W;
  localparam int IW          = $clog2(DEPTH);
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_ITEMS  = 900;

  logic clk;
  logic rst;
  bit   quiet_stretch;
  bit   hold_results;

  deq_cmd_if cmd_ch ();
  deq_res_if res_ch ();

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Mirror of the ring store; holds the results still owed by the block.
  class deque_mirror;
    logic [WW-1:0]      ring [DEPTH];
    int                 head_slot;
    int                 occupancy;
    deq_pkg::deq_res_t  pending_results [$];
    int                 mismatches;

    function new();
      head_slot  = 0;
      occupancy  = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [WW-1:0] got, logic [WW-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task note_cmd(deq_pkg::deq_cmd_t c);
      deq_pkg::deq_res_t want;
      want = '0;
      case (c.func)
        deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
          if (occupancy >= DEPTH) begin
            want.overflow = 1'b1;
          end else if (c.func == deq_pkg::FN_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring[IW'(head_slot)] = c.value;
            occupancy++;
          end else begin
            ring[IW'((head_slot + occupancy) % DEPTH)] = c.value;
            occupancy++;
          end
        end
        default: begin
          if (occupancy == 0) begin
            want.underflow = 1'b1;
          end else if (c.func == deq_pkg::FN_POP_FRONT) begin
            want.popped = ring[IW'(head_slot)];
            head_slot = (head_slot + 1) % DEPTH;
            occupancy--;
          end else begin
            want.popped = ring[IW'((head_slot + occupancy - 1) % DEPTH)];
            occupancy--;
          end
        end
      endcase
      if (occupancy != 0) begin
        want.head_word = ring[IW'(head_slot)];
        want.tail_word = ring[IW'((head_slot + occupancy - 1) % DEPTH)];
        want.nonempty  = 1'b1;
      end
      want.count = CW'(occupancy);
      pending_results.push_back(want);
    endtask

    task check_res(deq_pkg::deq_res_t got);
      deq_pkg::deq_res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("popped", got.popped, want.popped);
      compare_field("head_word", got.head_word, want.head_word);
      compare_field("tail_word", got.tail_word, want.tail_word);
      compare_field("nonempty", WW'(got.nonempty), WW'(want.nonempty));
      compare_field("count", WW'(got.count), WW'(want.count));
      compare_field("underflow", WW'(got.underflow), WW'(want.underflow));
      compare_field("overflow", WW'(got.overflow), WW'(want.overflow));
    endtask
  endclass

  deque_mirror mirror = new();

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) mirror.note_cmd(cmd_ch.data);
      if (res_ch.valid && res_ch.ready) mirror.check_res(res_ch.data);
    end
  end

  // Result side: random back-pressure, a quiet stretch, and one long hold-off.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= quiet_stretch || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        still = 0;
      else
        still++;
    end
    $display("double_ended_queue regression: fail");
    $finish;
  end

  task automatic send_item(input deq_pkg::deq_func_t f, input logic [WW-1:0] v);
    while (!quiet_stretch && $urandom_range(99) < 31) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.data.func  <= f;
    cmd_ch.data.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Stop offering and hold until every owed result has come back.
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.pending_results.size() != 0);
  endtask

  function automatic deq_pkg::deq_func_t pick_func(int push_pct);
    if ($urandom_range(99) < push_pct) begin
      if ($urandom_range(1) == 1) return deq_pkg::FN_PUSH_BACK;
      return deq_pkg::FN_PUSH_FRONT;
    end
    if ($urandom_range(1) == 1) return deq_pkg::FN_POP_BACK;
    return deq_pkg::FN_POP_FRONT;
  endfunction

  function automatic logic [WW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.data       <= '0;
    quiet_stretch     = 1'b0;
    hold_results      = 1'b0;
    push_pct          = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Underflow on both ends, extremes, fill to full, overflow on both ends.
    send_item(deq_pkg::FN_POP_FRONT, 32'h0000_0000);
    send_item(deq_pkg::FN_POP_BACK, 32'hFFFF_FFFF);
    send_item(deq_pkg::FN_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(deq_pkg::FN_PUSH_FRONT, 32'h8000_0000);
    for (int i = 0; i < DEPTH - 2; i++) begin
      if (i % 2 == 1) send_item(deq_pkg::FN_PUSH_FRONT, 32'hAAAA_AAAA ^ i);
      else send_item(deq_pkg::FN_PUSH_BACK, 32'h5555_5555 ^ i);
    end
    send_item(deq_pkg::FN_PUSH_FRONT, 32'h1234_5678);
    send_item(deq_pkg::FN_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(deq_pkg::FN_POP_FRONT, 32'h0000_0000);
    send_item(deq_pkg::FN_POP_BACK, 32'h0000_0000);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if (n == 200 || n == 750) wait_for_results();
      if (n == 300) quiet_stretch = 1'b1;
      if (n == 450) quiet_stretch = 1'b0;
      if (n == 600) begin
        hold_results = 1'b1;
        push_pct     = 90;
      end
      send_item(pick_func(push_pct), pick_word());
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mirror.pending_results.size() != 0)
      mirror.report_mismatch("results still owed at end of run");
    if (mirror.mismatches == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
